// File: design/hec_pkg.sv
// Package with types, constants and helpers for the hashed entry cache.
package hec_pkg;

  localparam int ENTRIES      = 64;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int HEADER_LIMIT = 1024;
  localparam logic [23:0] HEADER_RESERVE = 24'd1024;

  // Stored entry word: hash, key, time, size, bytes, stamp.
  localparam int ENTRY_W = 32 + 64 + 32 + 24 + 25 + 32;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_BIG  = 3'd4;
  localparam logic [2:0] ST_LOAD_ERR = 3'd5;

  localparam logic CFG_BYTE_BUDGET = 1'b0;
  localparam logic CFG_MAX_ENTRY   = 1'b1;

  typedef struct packed {
    logic [31:0] key_hash;
    logic [63:0] key_id;
    logic [31:0] mod_time;
    logic [23:0] object_size;
    logic [10:0] header_length;
    logic        load_ok;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] bytes_in_use;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [63:0] key;
    logic [31:0] mtime;
    logic [23:0] size;
    logic [24:0] bytes;
    logic [31:0] stamp;
  } entry_t;

endpackage

// File: design/hec_ram.sv
// Generic single-port RAM with a registered read.
module hec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write at the address; the registered read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/hashed_entry_cache_lru_budget.sv
// Top level of the hashed entry cache with least-recently-used eviction.
// One request at a time: in_stall is high from acceptance until the result beat
// is taken. After acceptance a size check runs. The probe then walks the chain
// through the single entry RAM port, a read and a compare for each occupied slot
// and a check of the free slot that ends it. The header check and the budget
// compare follow. Each eviction scans all ENTRIES slots, reading each occupied
// one and comparing its stamp, then closes the scan, reads the oldest entry,
// frees it and returns to the budget compare. The fill or the failure follows.
// When the budget cannot be met with the table empty, one final scan ends the
// evictions. The result beat waits as long as out_stall holds. Slot valid bits
// live in flip-flops and are cleared at reset; no clearing pass.
module hashed_entry_cache_lru_budget (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hec_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hec_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PCMP  = 4'd3;
  localparam logic [3:0] S_HDR   = 4'd4;
  localparam logic [3:0] S_BUD   = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SCMP  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FREE  = 4'd9;
  localparam logic [3:0] S_FILL  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]                 state_r, state_nxt;
  logic [31:0]                budget_r;
  logic [23:0]                max_r;
  logic [31:0]                total_r, total_nxt;
  logic [31:0]                counter_r, counter_nxt;
  logic [hec_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  hec_pkg::in_beat_t          req_r, req_nxt;
  hec_pkg::out_beat_t         res_r, res_nxt;
  logic [hec_pkg::IDX_W-1:0]  idx_r, idx_nxt, target_r, target_nxt;
  logic [hec_pkg::IDX_W-1:0]  best_r, best_nxt;
  logic                       best_ok_r, best_ok_nxt;
  logic [31:0]                best_stamp_r, best_stamp_nxt;
  logic [hec_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [24:0]                need_r, need_nxt;

  logic                       ram_we;
  logic [hec_pkg::IDX_W-1:0]  ram_addr;
  hec_pkg::entry_t            ram_wdata, ram_rdata;

  hec_ram #(.WIDTH(hec_pkg::ENTRY_W), .DEPTH(hec_pkg::ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [23:0] limit;
  logic [32:0] sum_need;
  logic [32:0] sum_fill;

  assign limit    = (max_r > hec_pkg::HEADER_RESERVE) ? max_r - hec_pkg::HEADER_RESERVE : 24'd0;
  assign sum_need = {1'b0, total_r} + {8'd0, need_r};
  assign sum_fill = {1'b0, total_r} + {8'd0, need_r};
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= 32'd16777216;
      max_r    <= 24'd65536;
    end else if (cfg_we) begin
      if (cfg_index == hec_pkg::CFG_BYTE_BUDGET) budget_r <= cfg_wdata;
      else max_r <= cfg_wdata[23:0];
    end
  end

  // Sequencer: size check, probe, header check, budget evictions, fill.
  always_comb begin
    hec_pkg::entry_t fill;
    logic [31:0] bytes_sub;
    state_nxt      = state_r;
    total_nxt      = total_r;
    counter_nxt    = counter_r;
    valid_nxt      = valid_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    idx_nxt        = idx_r;
    target_nxt     = target_r;
    best_nxt       = best_r;
    best_ok_nxt    = best_ok_r;
    best_stamp_nxt = best_stamp_r;
    cnt_nxt        = cnt_r;
    need_nxt       = need_r;
    ram_we         = 1'b0;
    ram_addr       = idx_r;
    fill           = ram_rdata;
    ram_wdata      = ram_rdata;
    bytes_sub      = {7'd0, ram_rdata.bytes};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          counter_nxt = counter_r + 32'd1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt = req_r.key_hash[hec_pkg::IDX_W-1:0];
        cnt_nxt = '0;
        if (req_r.object_size == 24'd0 || req_r.object_size > limit) begin
          res_nxt   = '{hec_pkg::ST_BAD_SIZE, 6'd0, total_r};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        if (cnt_r == hec_pkg::CNT_W'(hec_pkg::ENTRIES)) begin
          res_nxt   = '{hec_pkg::ST_FULL, 6'd0, total_r};
          state_nxt = S_OUT;
        end else if (!valid_r[idx_r]) begin
          target_nxt = idx_r;
          state_nxt  = S_HDR;
        end else begin
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (ram_rdata.hash == req_r.key_hash && ram_rdata.key == req_r.key_id) begin
          if (ram_rdata.mtime == req_r.mod_time && ram_rdata.size == req_r.object_size) begin
            fill.stamp = counter_r;
            ram_wdata  = fill;
            ram_we     = 1'b1;
            res_nxt    = '{hec_pkg::ST_HIT, 6'(idx_r), total_r};
            state_nxt  = S_OUT;
          end else begin
            if (total_r >= bytes_sub) total_nxt = total_r - bytes_sub;
            valid_nxt[idx_r] = 1'b0;
            target_nxt = idx_r;
            state_nxt  = S_HDR;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_HDR: begin
        need_nxt = {14'd0, req_r.header_length} + {1'b0, req_r.object_size};
        if (req_r.header_length == 11'd0 ||
            {21'd0, req_r.header_length} >= 32'(hec_pkg::HEADER_LIMIT) ||
            ({14'd0, req_r.header_length} + {1'b0, req_r.object_size}) > {1'b0, max_r}) begin
          res_nxt   = '{hec_pkg::ST_TOO_BIG, 6'd0, total_r};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_BUD;
        end
      end
      S_BUD: begin
        idx_nxt     = '0;
        cnt_nxt     = '0;
        best_ok_nxt = 1'b0;
        if (sum_need > {1'b0, budget_r}) state_nxt = S_SRD;
        else state_nxt = S_FILL;
      end
      S_SRD: begin
        if (cnt_r == hec_pkg::CNT_W'(hec_pkg::ENTRIES)) begin
          if (best_ok_r) begin
            idx_nxt   = best_r;
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_FILL;
          end
        end else if (!valid_r[idx_r]) begin
          idx_nxt = idx_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!best_ok_r || ram_rdata.stamp < best_stamp_r) begin
          best_ok_nxt    = 1'b1;
          best_nxt       = idx_r;
          best_stamp_nxt = ram_rdata.stamp;
        end
        idx_nxt   = idx_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_FRD: begin
        state_nxt = S_FREE;
      end
      S_FREE: begin
        if (total_r >= bytes_sub) total_nxt = total_r - bytes_sub;
        valid_nxt[idx_r] = 1'b0;
        state_nxt = S_BUD;
      end
      S_FILL: begin
        ram_addr = target_r;
        if (!req_r.load_ok) begin
          res_nxt = '{hec_pkg::ST_LOAD_ERR, 6'd0, total_r};
        end else begin
          fill       = '{req_r.key_hash, req_r.key_id, req_r.mod_time,
                         req_r.object_size, need_r, counter_r};
          ram_wdata  = fill;
          ram_we     = 1'b1;
          valid_nxt[target_r] = 1'b1;
          total_nxt  = sum_fill[32] ? 32'hFFFF_FFFF : sum_fill[31:0];
          res_nxt    = '{hec_pkg::ST_LOADED, 6'(target_r), total_nxt};
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      counter_r <= '0;
      valid_r   <= '0;
      best_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      counter_r <= counter_nxt;
      valid_r   <= valid_nxt;
      best_ok_r <= best_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    res_r        <= res_nxt;
    idx_r        <= idx_nxt;
    target_r     <= target_nxt;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    cnt_r        <= cnt_nxt;
    need_r       <= need_nxt;
  end

endmodule

// File: design/hec_checker.sv
// Port-level checks for the hashed entry cache, bound to the top level.
module hec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hec_pkg::out_beat_t out_data
);

  // A result beat only appears while a request is held.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result beat while idle");

  // An accepted request makes the block busy next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= hec_pkg::ST_LOAD_ERR) else $error("bad status");

  // Slot index is zero unless hit or loaded.
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != hec_pkg::ST_HIT && out_data.status != hec_pkg::ST_LOADED)
      |-> out_data.slot_index == 6'd0) else $error("slot on failure");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data))) else $error("dropped");

endmodule

bind hashed_entry_cache_lru_budget hec_checker u_hec_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the hashed entry cache with LRU eviction and a byte budget.
`timescale 1ns / 100ps

// Tracks the cache contents and queues the result expected for each request.
class cache_scoreboard;
  bit          vld   [hec_pkg::ENTRIES];
  logic [31:0] hsh   [hec_pkg::ENTRIES];
  logic [63:0] key   [hec_pkg::ENTRIES];
  logic [31:0] mtm   [hec_pkg::ENTRIES];
  logic [23:0] sz    [hec_pkg::ENTRIES];
  logic [31:0] nbytes[hec_pkg::ENTRIES];
  logic [31:0] stamp [hec_pkg::ENTRIES];
  logic [31:0] in_use;
  logic [31:0] req_count;
  logic [31:0] budget;
  logic [23:0] max_entry;
  hec_pkg::out_beat_t pending[$];
  int errors;

  function void clear();
    for (int i = 0; i < hec_pkg::ENTRIES; i++) vld[i] = 0;
    in_use = 0;
    req_count = 0;
    budget = 32'd16777216;
    max_entry = 24'd65536;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic idx, logic [31:0] value);
    if (idx == hec_pkg::CFG_BYTE_BUDGET) budget = value;
    else max_entry = value[23:0];
  endfunction

  function void evict(int i);
    if (!vld[i]) return;
    if (in_use >= nbytes[i]) in_use = in_use - nbytes[i];
    vld[i] = 0;
  endfunction

  function void push(logic [2:0] st, int slot);
    hec_pkg::out_beat_t r;
    r.status = st;
    r.slot_index = slot[5:0];
    r.bytes_in_use = in_use;
    pending.push_back(r);
  endfunction

  // Notes an accepted request and predicts its result.
  function void note_request(hec_pkg::in_beat_t b);
    logic [31:0] lim;
    logic [31:0] total;
    int idx;
    int target;
    int oldest;
    bit found;
    found = 0;
    target = 0;
    req_count = req_count + 1;
    lim = (max_entry > 1024) ? max_entry - 1024 : 0;
    if (b.object_size == 0 || b.object_size > lim) begin
      push(hec_pkg::ST_BAD_SIZE, 0);
      return;
    end
    idx = b.key_hash % hec_pkg::ENTRIES;
    for (int p = 0; p < hec_pkg::ENTRIES; p++) begin
      if (!vld[idx]) begin
        target = idx;
        found = 1;
        break;
      end
      if (hsh[idx] == b.key_hash && key[idx] == b.key_id) begin
        if (mtm[idx] == b.mod_time && sz[idx] == b.object_size) begin
          stamp[idx] = req_count;
          push(hec_pkg::ST_HIT, idx);
          return;
        end
        evict(idx);
        target = idx;
        found = 1;
        break;
      end
      idx = (idx + 1) % hec_pkg::ENTRIES;
    end
    if (!found) begin
      push(hec_pkg::ST_FULL, 0);
      return;
    end
    if (b.header_length == 0 || b.header_length >= hec_pkg::HEADER_LIMIT) begin
      push(hec_pkg::ST_TOO_BIG, 0);
      return;
    end
    total = b.header_length + b.object_size;
    if (total > max_entry) begin
      push(hec_pkg::ST_TOO_BIG, 0);
      return;
    end
    // Evict the least recently used entries until the new one fits.
    while ({1'b0, in_use} + total > {1'b0, budget}) begin
      oldest = -1;
      for (int i = 0; i < hec_pkg::ENTRIES; i++)
        if (vld[i] && (oldest < 0 || stamp[i] < stamp[oldest])) oldest = i;
      if (oldest < 0) break;
      evict(oldest);
    end
    if (!b.load_ok) begin
      push(hec_pkg::ST_LOAD_ERR, 0);
      return;
    end
    vld[target] = 1;
    hsh[target] = b.key_hash;
    key[target] = b.key_id;
    mtm[target] = b.mod_time;
    sz[target] = b.object_size;
    nbytes[target] = total;
    stamp[target] = req_count;
    if (in_use > 32'hFFFF_FFFF - total) in_use = 32'hFFFF_FFFF;
    else in_use = in_use + total;
    push(hec_pkg::ST_LOADED, target);
  endfunction

  // Compares one result beat with the oldest prediction.
  function void check_result(hec_pkg::out_beat_t r);
    hec_pkg::out_beat_t e;
    if (pending.size() == 0) begin
      $error("result beat with no request pending: %h", r);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (r.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, r.status);
      errors++;
    end
    if (r.slot_index !== e.slot_index) begin
      $error("slot_index: expected %0d, actual %0d", e.slot_index, r.slot_index);
      errors++;
    end
    if (r.bytes_in_use !== e.bytes_in_use) begin
      $error("bytes_in_use: expected %0d, actual %0d", e.bytes_in_use, r.bytes_in_use);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  hec_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  hec_pkg::out_beat_t out_data;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors_seen = 0;
  cache_scoreboard sb;

  // Small pool of keys so that hits, stale refills and long chains occur.
  logic [31:0] pool_hash[16];
  logic [63:0] pool_key[16];
  logic [31:0] pool_time[16];
  logic [23:0] pool_size[16];

  hashed_entry_cache_lru_budget dut (.*);

  always #5 clk = ~clk;

  // Receiver: random stall, check each accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(hec_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b);
    in_valid <= 0;
    // The block is busy after an accept.
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    // Wait until every result is back, then let the block settle.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic hec_pkg::in_beat_t make_beat(logic [31:0] h, logic [63:0] k,
                                                  logic [31:0] t, logic [23:0] s,
                                                  logic [10:0] hl, logic ok);
    hec_pkg::in_beat_t b;
    b.key_hash = h;
    b.key_id = k;
    b.mod_time = t;
    b.object_size = s;
    b.header_length = hl;
    b.load_ok = ok;
    return b;
  endfunction

  function automatic hec_pkg::in_beat_t random_beat();
    hec_pkg::in_beat_t b;
    int p;
    int r;
    p = $urandom_range(15);
    r = $urandom_range(99);
    b = make_beat(pool_hash[p], pool_key[p], pool_time[p], pool_size[p],
                  11'($urandom_range(1, 1023)), ($urandom_range(9) != 0));
    if (r < 8) begin
      // Stale version of a pooled key.
      b.mod_time = $urandom;
      pool_time[p] = b.mod_time;
    end else if (r < 12) begin
      b.object_size = 24'($urandom_range(1, 3000));
      pool_size[p] = b.object_size;
    end else if (r < 20) begin
      // Fully random noise.
      b = make_beat($urandom | 32'd1, {$urandom, $urandom}, $urandom,
                    24'($urandom_range(0, 24'hFFFFFF)), 11'($urandom_range(0, 2047)),
                    1'($urandom_range(1)));
    end else if (r < 23) begin
      b.header_length = ($urandom_range(1)) ? 11'd0 : 11'($urandom_range(1024, 2047));
    end else if (r < 25) begin
      b.key_id = {$urandom, $urandom};
    end
    return b;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_request(random_beat());
  endtask

  initial begin
    sb = new();
    sb.clear();
    for (int i = 0; i < 16; i++) begin
      // Several keys share home slots to build probe chains.
      pool_hash[i] = {26'($urandom_range(0, 32'h3FFFFFF)), 6'($urandom_range(3))};
      if (pool_hash[i] == 0) pool_hash[i] = 32'h40;
      pool_key[i] = {$urandom, $urandom};
      pool_time[i] = $urandom;
      pool_size[i] = 24'($urandom_range(1, 3000));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: size limits, header limits, hit, stale refill, load failure.
    send_request(make_beat(32'h1, 64'h1, 32'h0, 24'd0, 11'd100, 1));
    send_request(make_beat(32'h1, 64'h1, 32'h0, 24'd64513, 11'd100, 1));
    send_request(make_beat(32'h1, 64'h1, 32'h0, 24'd64512, 11'd1023, 1));
    send_request(make_beat(32'h1, 64'h1, 32'h0, 24'd64512, 11'd1024, 1));
    send_request(make_beat(32'h1, 64'h1, 32'h0, 24'd64512, 11'd0, 1));
    send_request(make_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                           24'd1, 11'd2047, 1));
    send_request(make_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                           24'd1, 11'd1, 1));
    send_request(make_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                           24'd1, 11'd1, 1));
    send_request(make_beat(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5,
                           24'd1, 11'd1, 0));
    send_request(make_beat(32'h41, 64'h2, 32'h7, 24'd500, 11'd10, 1));
    send_request(make_beat(32'h81, 64'h3, 32'h7, 24'd500, 11'd10, 1));
    send_request(make_beat(32'h41, 64'h2, 32'h7, 24'd501, 11'd10, 1));

    // Tiny budget forces eviction; then fill the whole table on one chain.
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'd2000);
    send_request(make_beat(32'h2, 64'h10, 32'h1, 24'd900, 11'd100, 1));
    send_request(make_beat(32'h3, 64'h11, 32'h1, 24'd900, 11'd100, 1));
    send_request(make_beat(32'h4, 64'h12, 32'h1, 24'd1500, 11'd100, 0));
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
    for (int i = 0; i < 66; i++)
      send_request(make_beat(32'h5 + 64 * i, 64'(i + 100), 32'h1, 24'd10, 11'd10, 1));
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'd0);
    send_request(make_beat(32'h9, 64'h9, 32'h1, 24'd10, 11'd10, 1));

    // Extremes of the entry size limit.
    write_reg(hec_pkg::CFG_MAX_ENTRY, 32'd1025);
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'd16777216);
    send_request(make_beat(32'h6, 64'h6, 32'h1, 24'd1, 11'd1, 1));
    send_request(make_beat(32'h7, 64'h7, 32'h1, 24'd1, 11'd2, 1));
    write_reg(hec_pkg::CFG_MAX_ENTRY, 32'hFFFFFF);
    send_request(make_beat(32'h8, 64'h8, 32'h1, 24'hFFFFFF, 11'd5, 1));
    send_request(make_beat(32'h8, 64'h8, 32'h1, 24'hFBFF00, 11'd5, 1));

    // Random phases with the three idling profiles and several settings.
    write_reg(hec_pkg::CFG_MAX_ENTRY, 32'd4096);
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'd20000);
    send_idle_pct = 7;
    recv_stall_pct = 87;
    random_phase(400);
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'd6000);
    send_idle_pct = 87;
    recv_stall_pct = 7;
    random_phase(450);
    write_reg(hec_pkg::CFG_BYTE_BUDGET, 32'hFFFF_FFFF);
    write_reg(hec_pkg::CFG_MAX_ENTRY, 32'd65536);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(450);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    errors_seen = sb.errors;
    if (errors_seen == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #300ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: sim.f
design/hec_pkg.sv
design/hec_ram.sv
design/hashed_entry_cache_lru_budget.sv
design/hec_checker.sv
tb/sv/tb_top.sv
